FILE: hw/rtl/scfr_pkg.sv
package scfr_pkg;

    // Input item kinds, carried on the slave-side tuser.
    localparam logic [1:0] IN_BYTE = 2'd0;
    localparam logic [1:0] IN_TICK = 2'd1;
    localparam logic [1:0] IN_POP  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_DEVICE_ID = 1'b0;
    localparam logic CFG_TIMEOUT   = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd200;

    // Frame and reply bytes.
    localparam logic [7:0] CMD_SYNC0  = 8'h03;
    localparam logic [7:0] CMD_SYNC1  = 8'h02;
    localparam logic [7:0] DATA_SYNC0 = 8'h04;
    localparam logic [7:0] DATA_SYNC1 = 8'h05;
    localparam logic [7:0] ACK_CODE   = 8'h00;
    localparam logic [7:0] NACK_CODE  = 8'hFF;
    localparam int         CMD_DATA_BIT = 7;

    // Depth of the job queue between front and back.
    localparam int JOB_DEPTH = 4;

    typedef enum logic [1:0] {
        JOB_ACK,
        JOB_NACK,
        JOB_POP,
        JOB_EMPTY
    } job_kind_t;

    typedef struct packed {
        logic [7:0] command;
        logic [7:0] data0;
        logic [7:0] data1;
        logic [7:0] data2;
        logic [7:0] data3;
    } entry_t;

    typedef struct packed {
        job_kind_t kind;
        entry_t    entry;
    } job_t;

    // Byte k of an ACK or NACK reply frame; the last byte is the 8-bit sum.
    function automatic logic [7:0] reply_byte(input logic ack, input logic [1:0] idx);
        logic [7:0] code;
        logic [7:0] b;
        begin
            code = ack ? ACK_CODE : NACK_CODE;
            case (idx)
                2'd0:    b = CMD_SYNC0;
                2'd1:    b = CMD_SYNC1;
                2'd2:    b = code;
                default: b = CMD_SYNC0 + CMD_SYNC1 + code;
            endcase
            return b;
        end
    endfunction

endpackage

FILE: hw/rtl/serial_command_frame_receiver.sv
// Serial command frame receiver. Each slave-side beat is a received byte, a
// millisecond tick or a request to pop the command queue. Command frames
// (03 02 cmd sum) and, for commands with bit 7 set, the following data frames
// (04 05 d0 d1 d2 d3 sum) are checked and stored in a queue of QUEUE_DEPTH
// slots holding at most QUEUE_DEPTH-1 commands; each verdict or timeout gives
// a four-beat ACK (03 02 00 05) or NACK (03 02 FF 04) reply, and each pop gives
// one beat with the entry or an empty flag. The front accepts one beat per
// cycle while its issue stage is free or being emptied, and passes its jobs
// through a four-entry queue to the back, which drives the master side at
// one beat per cycle while the master is ready; a reply holds the output for its
// four beats, a pop for one. An accepted beat reaches its first result beat
// through the issue stage, job queue and output register. Configuration
// writes take effect at once and should be made while the block is idle.
module serial_command_frame_receiver
    import scfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic [1:0]  s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tx_byte, entry_command, entry_data0, entry_data1, entry_data2, entry_data3
    output logic [47:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // tx_valid, pop_valid, queue_empty
    output logic        m_axis_tlast    // last
);

    logic f_valid;
    logic f_ready;
    job_t f_job;
    logic q_valid;
    logic q_ready;
    job_t q_job;

    scfr_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser),
        .in_byte   (s_axis_tdata),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    scfr_job_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_job   (f_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_job    (q_job)
    );

    scfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    // A pop result is always a single beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[1] || m_axis_tuser[2]) |-> m_axis_tlast)
        else $error("pop result not marked last");

    // A beat carries exactly one kind of result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot(m_axis_tuser))
        else $error("result beat kind flags not one-hot");

    // The closing beat of a reply is its checksum byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] && m_axis_tlast |->
            (m_axis_tdata[7:0] == 8'h05 || m_axis_tdata[7:0] == 8'h04))
        else $error("reply ends without checksum byte");

    // A reply beat that follows an unfinished reply beat continues that reply.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(m_axis_tvalid && m_axis_tready && m_axis_tuser[0] && !m_axis_tlast)
            && m_axis_tvalid |-> m_axis_tuser[0])
        else $error("reply frame interrupted");

endmodule

FILE: hw/rtl/scfr_front.sv
module scfr_front
    import scfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [15:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_kind,
    input  logic [7:0] in_byte,
    output logic       job_valid,
    input  logic       job_ready,
    output job_t       job
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    function automatic logic [QW-1:0] wrap_inc(input logic [QW-1:0] p);
        begin
            return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        end
    endfunction

    // Configuration registers.
    logic        dev_id_reg;
    logic [15:0] timeout_reg;

    // Frame collection state.
    logic        phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [7:0]  sum_reg, sum_next;
    logic        hdr_ok_reg, hdr_ok_next;
    logic [7:0]  cmd_hold_reg, cmd_hold_next;
    logic [7:0]  d0_reg, d0_next;
    logic [7:0]  d1_reg, d1_next;
    logic [7:0]  d2_reg, d2_next;
    logic [7:0]  d3_reg, d3_next;
    logic [15:0] idle_reg, idle_next;
    logic [15:0] dwait_reg, dwait_next;

    // Command queue pointers and storage.
    logic [QW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_DEPTH-1:0] dvld_reg, dvld_next;
    logic [7:0]             cmd_mem  [QUEUE_DEPTH];
    logic [31:0]            data_mem [QUEUE_DEPTH];
    logic                   cmd_we;
    logic                   data_we;
    logic                   mem_rd;

    // Issue stage holding the job while the popped entry is read.
    logic       b_valid_reg, b_valid_next;
    job_kind_t  b_kind_reg, b_kind_next;
    logic [7:0] rd_cmd_reg;
    logic [31:0] rd_data_reg;
    logic       rd_dvld_reg;

    logic        accept;
    logic        b_advance;
    logic        new_job;
    job_kind_t   new_kind;
    logic        full;
    logic        frame_ok;
    logic [15:0] idle_inc;
    logic [15:0] dwait_inc;
    logic [7:0]  sync0;
    logic [7:0]  sync1;

    assign b_advance = b_valid_reg && job_ready;
    assign in_ready  = !b_valid_reg || job_ready;
    assign accept    = in_valid && in_ready;
    assign full      = (wrap_inc(wr_ptr_reg) == rd_ptr_reg);
    assign idle_inc  = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign dwait_inc = (dwait_reg == 16'hFFFF) ? dwait_reg : dwait_reg + 16'd1;
    assign sync0     = phase_reg ? DATA_SYNC0 : CMD_SYNC0;
    assign sync1     = phase_reg ? DATA_SYNC1 : CMD_SYNC1;
    assign frame_ok  = hdr_ok_reg && (in_byte == sum_reg) && (phase_reg || dev_id_reg);

    // Frame collection, timers and queue bookkeeping for one accepted item.
    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        hdr_ok_next   = hdr_ok_reg;
        cmd_hold_next = cmd_hold_reg;
        d0_next       = d0_reg;
        d1_next       = d1_reg;
        d2_next       = d2_reg;
        d3_next       = d3_reg;
        idle_next     = idle_reg;
        dwait_next    = dwait_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        dvld_next     = dvld_reg;
        cmd_we        = 1'b0;
        data_we       = 1'b0;
        mem_rd        = 1'b0;
        new_job       = 1'b0;
        new_kind      = JOB_NACK;

        if (accept)
        begin
            case (in_kind)
                IN_BYTE:
                begin
                    idle_next = '0;
                    cnt_next  = cnt_reg + 3'd1;
                    sum_next  = (cnt_reg == 3'd0) ? in_byte : sum_reg + in_byte;
                    if (cnt_reg == 3'd0)
                    begin
                        hdr_ok_next = (in_byte == sync0);
                    end
                    else if (cnt_reg == 3'd1)
                    begin
                        hdr_ok_next = hdr_ok_reg && (in_byte == sync1);
                    end
                    else if (phase_reg && cnt_reg == 3'd5)
                    begin
                        hdr_ok_next = hdr_ok_reg &&
                                      (in_byte == ACK_CODE || in_byte == NACK_CODE);
                    end
                    case (cnt_reg)
                        3'd2:    begin cmd_hold_next = in_byte; d0_next = in_byte; end
                        3'd3:    d1_next = in_byte;
                        3'd4:    d2_next = in_byte;
                        3'd5:    d3_next = in_byte;
                        default: ;
                    endcase

                    // Command frame verdict on its fourth byte.
                    if (!phase_reg && cnt_reg == 3'd3)
                    begin
                        cnt_next = '0;
                        if (!frame_ok || full)
                        begin
                            new_job  = 1'b1;
                            new_kind = JOB_NACK;
                        end
                        else
                        begin
                            cmd_we = 1'b1;
                            if (cmd_hold_reg[CMD_DATA_BIT])
                            begin
                                phase_next = 1'b1;
                                dwait_next = '0;
                            end
                            else
                            begin
                                wr_ptr_next = wrap_inc(wr_ptr_reg);
                                new_job     = 1'b1;
                                new_kind    = JOB_ACK;
                            end
                        end
                    end

                    // Data frame verdict on its seventh byte.
                    if (phase_reg && cnt_reg == 3'd6)
                    begin
                        cnt_next   = '0;
                        phase_next = 1'b0;
                        new_job    = 1'b1;
                        if (!frame_ok || full)
                        begin
                            new_kind = JOB_NACK;
                        end
                        else
                        begin
                            data_we               = 1'b1;
                            dvld_next[wr_ptr_reg] = 1'b1;
                            wr_ptr_next           = wrap_inc(wr_ptr_reg);
                            new_kind              = JOB_ACK;
                        end
                    end
                end
                IN_TICK:
                begin
                    idle_next  = idle_inc;
                    dwait_next = dwait_inc;
                    if ((cnt_reg != 3'd0 && idle_inc > timeout_reg) ||
                        (phase_reg && dwait_inc > timeout_reg))
                    begin
                        cnt_next   = '0;
                        phase_next = 1'b0;
                        new_job    = 1'b1;
                        new_kind   = JOB_NACK;
                    end
                end
                IN_POP:
                begin
                    new_job = 1'b1;
                    if (rd_ptr_reg == wr_ptr_reg)
                    begin
                        new_kind = JOB_EMPTY;
                    end
                    else
                    begin
                        new_kind    = JOB_POP;
                        mem_rd      = 1'b1;
                        rd_ptr_next = wrap_inc(rd_ptr_reg);
                    end
                end
                default: ;
            endcase
        end
    end

    // Issue stage handshake.
    always_comb
    begin
        b_kind_next = b_kind_reg;
        if (accept)
        begin
            b_valid_next = new_job;
            b_kind_next  = new_kind;
        end
        else if (b_advance)
        begin
            b_valid_next = 1'b0;
        end
        else
        begin
            b_valid_next = b_valid_reg;
        end
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_id_reg  <= 1'b0;
            timeout_reg <= TIMEOUT_RESET;
            phase_reg   <= 1'b0;
            cnt_reg     <= '0;
            idle_reg    <= '0;
            dwait_reg   <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            dvld_reg    <= '0;
            b_valid_reg <= 1'b0;
            b_kind_reg  <= JOB_NACK;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_DEVICE_ID)
            begin
                dev_id_reg <= cfg_data[0];
            end
            if (cfg_we && cfg_index == CFG_TIMEOUT)
            begin
                timeout_reg <= cfg_data;
            end
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            idle_reg    <= idle_next;
            dwait_reg   <= dwait_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            dvld_reg    <= dvld_next;
            b_valid_reg <= b_valid_next;
            b_kind_reg  <= b_kind_next;
        end
    end

    // Frame payload registers.
    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        hdr_ok_reg   <= hdr_ok_next;
        cmd_hold_reg <= cmd_hold_next;
        d0_reg       <= d0_next;
        d1_reg       <= d1_next;
        d2_reg       <= d2_next;
        d3_reg       <= d3_next;
    end

    // Command queue memories with registered read.
    always_ff @(posedge clk)
    begin
        if (cmd_we)
        begin
            cmd_mem[wr_ptr_reg] <= cmd_hold_reg;
        end
        if (data_we)
        begin
            data_mem[wr_ptr_reg] <= {d0_reg, d1_reg, d2_reg, d3_reg};
        end
        if (mem_rd)
        begin
            rd_cmd_reg  <= cmd_mem[rd_ptr_reg];
            rd_data_reg <= data_mem[rd_ptr_reg];
            rd_dvld_reg <= dvld_reg[rd_ptr_reg];
        end
    end

    // Job toward the back; data bytes of a slot never filled read as zero.
    always_comb
    begin
        job       = '0;
        job.kind  = b_kind_reg;
        if (b_kind_reg == JOB_POP)
        begin
            job.entry.command = rd_cmd_reg;
            if (rd_dvld_reg)
            begin
                {job.entry.data0, job.entry.data1, job.entry.data2, job.entry.data3} =
                    rd_data_reg;
            end
        end
    end

    assign job_valid = b_valid_reg;

endmodule

FILE: hw/rtl/scfr_job_fifo.sv
module scfr_job_fifo
    import scfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    localparam int PW = $clog2(JOB_DEPTH);

    job_t          slot_reg [JOB_DEPTH];
    logic [PW-1:0] wr_reg;
    logic [PW-1:0] rd_reg;
    logic [PW:0]   count_reg;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != (PW + 1)'(JOB_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_job    = slot_reg[rd_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_job;
        end
    end

endmodule

FILE: hw/rtl/scfr_back.sv
module scfr_back
    import scfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    output logic        job_ready,
    input  job_t        job,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [47:0] out_data,
    output logic [2:0]  out_user,
    output logic        out_last
);

    logic        out_valid_reg;
    logic [47:0] out_data_reg, out_data_next;
    logic [2:0]  out_user_reg, out_user_next;
    logic        out_last_reg, out_last_next;
    logic [1:0]  beat_reg, beat_next;
    logic        load;
    logic        is_reply;
    logic        final_beat;

    assign load       = !out_valid_reg || out_ready;
    assign is_reply   = (job.kind == JOB_ACK) || (job.kind == JOB_NACK);
    assign final_beat = !is_reply || (beat_reg == 2'd3);
    assign job_ready  = load && final_beat;

    // Build the next output beat from the job at the queue head.
    always_comb
    begin
        out_data_next = '0;
        out_user_next = '0;
        out_last_next = final_beat;
        beat_next     = beat_reg;
        if (load && job_valid)
        begin
            beat_next = final_beat ? 2'd0 : beat_reg + 2'd1;
        end
        case (job.kind)
            JOB_ACK, JOB_NACK:
            begin
                out_data_next[7:0] = reply_byte(job.kind == JOB_ACK, beat_reg);
                out_user_next[0]   = 1'b1;
            end
            JOB_POP:
            begin
                out_data_next[47:8] = {job.entry.data3, job.entry.data2, job.entry.data1,
                                       job.entry.data0, job.entry.command};
                out_user_next[1]    = 1'b1;
            end
            default:
            begin
                out_user_next[2] = 1'b1;
            end
        endcase
    end

    // Output valid and beat counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            beat_reg      <= '0;
        end
        else
        begin
            beat_reg <= beat_next;
            if (load)
            begin
                out_valid_reg <= job_valid;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load && job_valid)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
            out_last_reg <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

endmodule
